@@ hdl/atrlc_pkg.sv @@
// Package for the AT response line classifier: sizes, character codes,
// match patterns, class codes and the beat struct between the top and the line store.
// No dependencies.
package atrlc_pkg;

  // Line store holds up to LINE_CAPACITY-1 bytes (legal range 9..256).
  localparam int LINE_CAPACITY = 64;
  localparam int StoreCntW     = $clog2(LINE_CAPACITY);
  localparam logic [StoreCntW-1:0] StoreMax = StoreCntW'(LINE_CAPACITY - 1);

  // Text length saturates at 8: no test looks past "8 or more".
  localparam int TxtLenW = 4;
  localparam logic [TxtLenW-1:0] TxtLenSat = 4'd8;

  localparam int WinW = 56;

  localparam logic [7:0] CharLf  = 8'h0A;
  localparam logic [7:0] CharCr  = 8'h0D;
  localparam logic [7:0] CharNul = 8'h00;

  // Patterns packed with the first character in the top byte.
  localparam logic [55:0] PatSendOk     = 56'h53454E44204F4B;  // "SEND OK"
  localparam logic [47:0] PatClosed     = 48'h434C4F534544;    // "CLOSED"
  localparam logic [55:0] PatCommaClose = 56'h2C434C4F534544;  // ",CLOSED"
  localparam logic [39:0] PatError      = 40'h4552524F52;      // "ERROR"
  localparam logic [31:0] PatBusy       = 32'h62757379;        // "busy"

  typedef enum logic [1:0] {
    CLS_NONE    = 2'd0,
    CLS_SEND_OK = 2'd1,
    CLS_CLOSED  = 2'd2,
    CLS_ERROR   = 2'd3
  } line_class_t;

  typedef struct packed {
    logic       take;
    logic [7:0] rx_byte;
  } store_beat_t;

endpackage

@@ hdl/atrlc_byte_if.sv @@
// Byte channel into the classifier: valid/ready handshake plus one received byte.
// No dependencies.
interface atrlc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ hdl/atrlc_class_if.sv @@
// Result channel out of the classifier: valid/ready handshake plus a 2-bit line class.
// No dependencies.
interface atrlc_class_if;
  logic       valid;
  logic       ready;
  logic [1:0] line_class;

  modport source (output valid, output line_class, input ready);
  modport sink (input valid, input line_class, output ready);
endinterface

@@ hdl/atrlc_line_store.sv @@
// Line store state (count, text length, head and tail windows) and line classification.
// Depends on atrlc_pkg.
module atrlc_line_store (
  input  logic                   clk,
  input  logic                   rst_n,
  input  atrlc_pkg::store_beat_t beat,
  output atrlc_pkg::line_class_t line_class
);

  logic [atrlc_pkg::StoreCntW-1:0] stored_cnt_r, stored_cnt_nxt;
  logic [atrlc_pkg::TxtLenW-1:0]   txt_len_r, txt_len_nxt;
  logic                            txt_ended_r, txt_ended_nxt;
  logic [atrlc_pkg::WinW-1:0]      head_r, head_nxt;
  logic [atrlc_pkg::WinW-1:0]      tail_r, tail_nxt;
  logic                            is_lf;
  logic                            keep;

  assign is_lf = (beat.rx_byte == atrlc_pkg::CharLf);
  assign keep  = (beat.rx_byte != atrlc_pkg::CharCr) && (stored_cnt_r < atrlc_pkg::StoreMax);

  // Tests in priority order; an empty line matches nothing.
  always_comb begin
    line_class = atrlc_pkg::CLS_NONE;
    if (is_lf && (stored_cnt_r != '0)) begin
      if (txt_len_r == 4'd7 && head_r == atrlc_pkg::PatSendOk) begin
        line_class = atrlc_pkg::CLS_SEND_OK;
      end else if (txt_len_r == 4'd6 && head_r[55:8] == atrlc_pkg::PatClosed) begin
        line_class = atrlc_pkg::CLS_CLOSED;
      end else if (txt_len_r >= 4'd8 && tail_r == atrlc_pkg::PatCommaClose) begin
        line_class = atrlc_pkg::CLS_CLOSED;
      end else if (txt_len_r == 4'd5 && head_r[55:16] == atrlc_pkg::PatError) begin
        line_class = atrlc_pkg::CLS_ERROR;
      end else if (txt_len_r >= 4'd4 && head_r[55:24] == atrlc_pkg::PatBusy) begin
        line_class = atrlc_pkg::CLS_ERROR;
      end
    end
  end

  always_comb begin
    stored_cnt_nxt = stored_cnt_r;
    txt_len_nxt    = txt_len_r;
    txt_ended_nxt  = txt_ended_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    if (beat.take) begin
      if (is_lf) begin
        stored_cnt_nxt = '0;
        txt_len_nxt    = '0;
        txt_ended_nxt  = 1'b0;
        head_nxt       = '0;
        tail_nxt       = '0;
      end else if (keep) begin
        stored_cnt_nxt = stored_cnt_r + 1'b1;
        if (!txt_ended_r) begin
          if (beat.rx_byte == atrlc_pkg::CharNul) begin
            txt_ended_nxt = 1'b1;
          end else begin
            for (int i = 0; i < 7; i++) begin
              if (txt_len_r == 4'(i)) begin
                head_nxt[8*(6-i) +: 8] = beat.rx_byte;
              end
            end
            tail_nxt = {tail_r[atrlc_pkg::WinW-9:0], beat.rx_byte};
            if (txt_len_r != atrlc_pkg::TxtLenSat) begin
              txt_len_nxt = txt_len_r + 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_cnt_r <= '0;
      txt_len_r    <= '0;
      txt_ended_r  <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
    end else begin
      stored_cnt_r <= stored_cnt_nxt;
      txt_len_r    <= txt_len_nxt;
      txt_ended_r  <= txt_ended_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
    end
  end

endmodule

@@ hdl/at_response_line_classifier.sv @@
// Top level of the AT response line classifier: byte handshake, line store, result skid.
// Depends on atrlc_pkg, atrlc_byte_if, atrlc_class_if and atrlc_line_store.
//
//  channel  | direction | payload             | handshake
//  ---------+-----------+---------------------+-------------------------
//  in_ch    | sink      | rx_byte    [7:0]    | valid/ready, beat on both
//  out_ch   | source    | line_class [1:0]    | valid/ready, beat on both
//
// Every input beat yields exactly one result beat, presented on out_ch the cycle
// after acceptance when the main result slot is free, later while out_ch stalls.
// Throughput is one byte per cycle while out_ch is not stalled: the line store updates in the accept cycle.
// Two result registers (main + skid) let a byte be accepted while a result waits;
// in_ch.ready drops only while the skid register is full.
// rst_n is synchronous, active low; it clears the line store and both result slots.
module at_response_line_classifier (
  input  logic clk,
  input  logic rst_n,
  atrlc_byte_if.sink    in_ch,
  atrlc_class_if.source out_ch
);

  atrlc_pkg::store_beat_t beat;
  atrlc_pkg::line_class_t cls;

  logic        accept;
  logic        pop;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_cls_r, out_cls_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  logic [1:0]  skid_cls_r, skid_cls_nxt;

  // Accept whenever the skid slot is free; the main slot may still be stalled.
  assign in_ch.ready = !skid_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = out_valid_r && out_ch.ready;

  assign beat.take    = accept;
  assign beat.rx_byte = in_ch.rx_byte;

  atrlc_line_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat       (beat),
    .line_class (cls)
  );

  // Result slots: the main register drives out_ch, the skid catches a beat
  // that arrives while the main register is stalled.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_cls_nxt    = out_cls_r;
    skid_valid_nxt = skid_valid_r;
    skid_cls_nxt   = skid_cls_r;
    if (skid_valid_r) begin
      // No accept possible here; advance the skid once the main slot drains.
      if (pop) begin
        out_cls_nxt    = skid_cls_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      if (out_valid_r && !pop) begin
        // Main slot stalled: hold the new result in the skid.
        skid_valid_nxt = 1'b1;
        skid_cls_nxt   = 2'(cls);
      end else begin
        out_valid_nxt = 1'b1;
        out_cls_nxt   = 2'(cls);
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    out_cls_r  <= out_cls_nxt;
    skid_cls_r <= skid_cls_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.line_class = out_cls_r;

`ifndef SYNTHESIS
  // The skid only fills behind a stalled main slot.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot full while main slot empty");

  // Only a line feed can produce a class other than none.
  a_class_on_lf_only: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cls != atrlc_pkg::CLS_NONE) |-> (in_ch.rx_byte == atrlc_pkg::CharLf))
    else $error("class reported for a byte that is not a line feed");

  // An accepted beat always lands somewhere: a result is pending next cycle.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted beat produced no pending result");

  // A full skid with a draining main slot moves into the main slot.
  a_skid_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && pop) |=> (out_valid_r && !skid_valid_r))
    else $error("skid result did not advance");
`endif

endmodule
